// ===== hdl/leveled_backoff_retry_timer_top_defines.svh =====
// Assertion helpers for the leveled backoff retry timer.
// Both expect clk and rst_n in scope and stay quiet while reset is held.
`ifndef LEVELED_BACKOFF_RETRY_TIMER_TOP_DEFINES_SVH
`define LEVELED_BACKOFF_RETRY_TIMER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LBRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lbrt_pkg.sv =====
package lbrt_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SEC_W      = 16;
  localparam int unsigned TIME_W     = 63;
  // 65535 seconds expressed in nanoseconds fits in 46 bits
  localparam int unsigned NS_W       = 46;
  localparam int unsigned PROD_W     = 2 * SEC_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [NS_W-1:0]  NS_PER_SEC = NS_W'(1_000_000_000);
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

  localparam logic [CNT_W-1:0] RETRIES_RST  = CNT_W'(5);
  localparam logic [SEC_W-1:0] MIN_WAIT_RST = SEC_W'(1);
  localparam logic [SEC_W-1:0] MAX_WAIT_RST = SEC_W'(60);

  // cycles the derived products need after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    REQ_ATTEMPT = 2'd0,
    REQ_SUCCESS = 2'd1,
    REQ_FAIL    = 2'd2,
    REQ_NEXT    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    LVL_IMMEDIATE   = 2'd0,
    LVL_CONSTANT    = 2'd1,
    LVL_LINEAR      = 2'd2,
    LVL_EXPONENTIAL = 2'd3
  } level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RETRIES  = 2'd0,
    CFG_MIN_WAIT = 2'd1,
    CFG_MAX_WAIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] retries;
    logic [SEC_W-1:0] min_wait;
    logic [SEC_W-1:0] max_wait;
    logic             prod_big;   // min_wait * retries above 16 bits
    logic [SEC_W-1:0] prod_lo;
    logic [NS_W-1:0]  prod_ns;
    logic [NS_W-1:0]  min_ns;
    logic [NS_W-1:0]  max_ns;
    logic             settled;
  } cfg_t;

  typedef struct packed {
    req_t              req;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [SEC_W-1:0] wait_seconds;
    logic [1:0]       level;
    logic [CNT_W-1:0] retry_count;
  } res_t;

endpackage

// ===== hdl/lbrt_in_if.sv =====
interface lbrt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [lbrt_pkg::TIME_W-1:0] now_ns;

  modport source (output valid, output req_type, output now_ns, input ready);
  modport sink   (input valid, input req_type, input now_ns, output ready);
endinterface

// ===== hdl/lbrt_out_if.sv =====
interface lbrt_out_if;
  logic                       valid;
  logic                       ready;
  logic [lbrt_pkg::SEC_W-1:0] wait_seconds;
  logic [1:0]                 level;
  logic [lbrt_pkg::CNT_W-1:0] retry_count;

  modport source (output valid, output wait_seconds, output level, output retry_count,
                  input ready);
  modport sink   (input valid, input wait_seconds, input level, input retry_count,
                  output ready);
endinterface

// ===== hdl/lbrt_cfg_if.sv =====
interface lbrt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lbrt_pkg::CFG_IDX_W-1:0]  index;
  logic [lbrt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/leveled_backoff_retry_timer_top.sv =====
// Leveled backoff retry timer.
// in_ch carries one event per transfer: req_type (attempt, success, fail,
// next interval) and the current time now_ns. out_ch returns exactly one
// result per event: the wait in seconds, the backoff level and the retry
// count as they stand after that event. cfg_ch writes the retry limit, the
// minimum wait and the maximum wait by register index; write it only while
// no event is in flight. cfg_ch.ready is always high.
// An event passes through the input register and then the result register
// before its result is presented on out_ch. Throughput: one event per cycle
// while out_ch is not stalled; each event updates the state as it moves
// from the input register into the result register, so the next event sees
// it at once. in_ch.ready is low after reset and after every register write
// while the derived wait products (minimum times retry limit, and the waits
// scaled to nanoseconds) pass through their two multiply registers.
// Reset: level immediate, count zero, wait zero, no attempt recorded, and the
// registers back to retry limit 5, minimum 1 s, maximum 60 s.
// When the receiver stalls, the result register holds its transfer and one
// more event still enters the input register before in_ch.ready drops.
`include "leveled_backoff_retry_timer_top_defines.svh"

module leveled_backoff_retry_timer_top (
  input logic        clk,
  input logic        rst_n,
  lbrt_in_if.sink    in_ch,
  lbrt_out_if.source out_ch,
  lbrt_cfg_if.sink   cfg_ch
);

  lbrt_pkg::cfg_t  cfg;
  lbrt_pkg::item_t s1_item_r;
  lbrt_pkg::res_t  res_nxt;
  lbrt_pkg::res_t  out_res_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            advance;
  logic            in_ready;
  logic            in_fire;
  logic            s1_fire;

  // configuration registers and their derived products
  lbrt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign cfg_ch.ready = 1'b1;

  // the result register moves on when empty or when its transfer completes
  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = cfg.settled && (!s1_valid_r || advance);
  assign in_fire  = in_ch.valid && in_ready;
  assign s1_fire  = s1_valid_r && advance;

  assign in_ch.ready = in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register: capture the event on its transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.req <= lbrt_pkg::req_t'(in_ch.req_type);
      s1_item_r.now <= in_ch.now_ns;
    end
  end

  // state update; commits when the event moves into the result register
  lbrt_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  // result register: hold until the receiver takes it
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.wait_seconds = out_res_r.wait_seconds;
  assign out_ch.level        = out_res_r.level;
  assign out_ch.retry_count  = out_res_r.retry_count;

  // no event enters while the derived products are still settling
  `LBRT_ASSERT_SAME(a_no_accept_unsettled, !cfg.settled, !in_fire, "event accepted while unsettled")

  // a success always clears the wait and the retry count
  `LBRT_ASSERT_NEXT(a_success_clears, s1_fire && s1_item_r.req == lbrt_pkg::REQ_SUCCESS, out_res_r.wait_seconds == '0 && out_res_r.retry_count == '0, "success left wait or count")

  // a stalled result holds its payload
  `LBRT_ASSERT_NEXT(a_out_holds, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_res_r), "stalled result changed")

  // a stalled event stays in the input register
  `LBRT_ASSERT_NEXT(a_s1_holds, s1_valid_r && !advance, s1_valid_r, "stalled event dropped")

endmodule

// ===== hdl/lbrt_cfg.sv =====
module lbrt_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [lbrt_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lbrt_pkg::CFG_DATA_W-1:0] wr_data,
  output lbrt_pkg::cfg_t                  cfg
);

  logic [lbrt_pkg::CNT_W-1:0]  retries_r, retries_nxt;
  logic [lbrt_pkg::SEC_W-1:0]  min_r, min_nxt;
  logic [lbrt_pkg::SEC_W-1:0]  max_r, max_nxt;
  logic [1:0]                  settle_r, settle_nxt;
  logic [lbrt_pkg::PROD_W-1:0] prod_r;
  logic [lbrt_pkg::NS_W-1:0]   prod_ns_r;
  logic [lbrt_pkg::NS_W-1:0]   min_ns_r;
  logic [lbrt_pkg::NS_W-1:0]   max_ns_r;

  always_comb begin
    retries_nxt = retries_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    if (wr_en) begin
      unique case (wr_index)
        lbrt_pkg::CFG_RETRIES:  retries_nxt = wr_data;
        lbrt_pkg::CFG_MIN_WAIT: min_nxt     = wr_data;
        lbrt_pkg::CFG_MAX_WAIT: max_nxt     = wr_data;
        default: ;
      endcase
    end
  end

  // restart the settle count on every write, then count down
  always_comb begin
    if (wr_en) begin
      settle_nxt = lbrt_pkg::SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retries_r <= lbrt_pkg::RETRIES_RST;
      min_r     <= lbrt_pkg::MIN_WAIT_RST;
      max_r     <= lbrt_pkg::MAX_WAIT_RST;
      settle_r  <= lbrt_pkg::SETTLE_CYCLES;
    end else begin
      retries_r <= retries_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      settle_r  <= settle_nxt;
    end
  end

  // derived products, two registered multiply steps
  always_ff @(posedge clk) begin
    prod_r    <= {{(lbrt_pkg::PROD_W-lbrt_pkg::CNT_W){1'b0}}, retries_r}
               * {{(lbrt_pkg::PROD_W-lbrt_pkg::SEC_W){1'b0}}, min_r};
    prod_ns_r <= {{(lbrt_pkg::NS_W-lbrt_pkg::SEC_W){1'b0}}, prod_r[lbrt_pkg::SEC_W-1:0]}
               * lbrt_pkg::NS_PER_SEC;
    min_ns_r  <= {{(lbrt_pkg::NS_W-lbrt_pkg::SEC_W){1'b0}}, min_r} * lbrt_pkg::NS_PER_SEC;
    max_ns_r  <= {{(lbrt_pkg::NS_W-lbrt_pkg::SEC_W){1'b0}}, max_r} * lbrt_pkg::NS_PER_SEC;
  end

  always_comb begin
    cfg.retries  = retries_r;
    cfg.min_wait = min_r;
    cfg.max_wait = max_r;
    cfg.prod_big = |prod_r[lbrt_pkg::PROD_W-1:lbrt_pkg::SEC_W];
    cfg.prod_lo  = prod_r[lbrt_pkg::SEC_W-1:0];
    cfg.prod_ns  = prod_ns_r;
    cfg.min_ns   = min_ns_r;
    cfg.max_ns   = max_ns_r;
    cfg.settled  = (settle_r == 2'd0);
  end

endmodule

// ===== hdl/lbrt_step.sv =====
module lbrt_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  lbrt_pkg::item_t item,
  input  lbrt_pkg::cfg_t  cfg,
  output lbrt_pkg::res_t  res_nxt
);

  logic [1:0]                   level_r, level_nxt;
  logic [lbrt_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [lbrt_pkg::SEC_W-1:0]   wait_r, wait_nxt;
  logic [lbrt_pkg::NS_W-1:0]    wait_ns_r, wait_ns_nxt;
  logic [lbrt_pkg::TIME_W-1:0]  last_r, last_nxt;

  logic                         has_attempt;
  logic                         prod_lt_wait;
  logic [lbrt_pkg::SEC_W-1:0]   sel_sec;
  logic [lbrt_pkg::NS_W-1:0]    sel_ns;
  logic [lbrt_pkg::TIME_W:0]    threshold;
  logic                         late;
  logic                         escalate;
  logic [1:0]                   level_up;
  logic [1:0]                   level_dn;
  logic [lbrt_pkg::SEC_W-1:0]   base_sec;
  logic [lbrt_pkg::NS_W-1:0]    base_ns;
  logic [lbrt_pkg::SEC_W:0]     w_raw;
  logic [lbrt_pkg::NS_W:0]      ns_raw;

  // threshold = last attempt + max(min, min(min * retries, wait)) seconds
  always_comb begin
    has_attempt  = (last_r != '0);
    prod_lt_wait = !cfg.prod_big && (cfg.prod_lo < wait_r);
    sel_sec      = prod_lt_wait ? cfg.prod_lo : wait_r;
    sel_ns       = prod_lt_wait ? cfg.prod_ns : wait_ns_r;
    if (sel_sec < cfg.min_wait) begin
      sel_ns = cfg.min_ns;
    end
    threshold = {1'b0, last_r}
              + {{(lbrt_pkg::TIME_W + 1 - lbrt_pkg::NS_W){1'b0}}, sel_ns};
    late      = {1'b0, item.now} > threshold;
    escalate  = (count_r >= cfg.retries);
    level_up  = (level_r == lbrt_pkg::LVL_EXPONENTIAL) ? level_r : level_r + 2'd1;
    level_dn  = (level_r == lbrt_pkg::LVL_IMMEDIATE) ? level_r : level_r - 2'd1;
  end

  always_comb begin
    level_nxt   = level_r;
    count_nxt   = count_r;
    wait_nxt    = wait_r;
    wait_ns_nxt = wait_ns_r;
    last_nxt    = last_r;
    base_sec    = wait_r;
    base_ns     = wait_ns_r;
    w_raw       = '0;
    ns_raw      = '0;
    unique case (item.req)
      lbrt_pkg::REQ_ATTEMPT: begin
        if (has_attempt && count_r != lbrt_pkg::COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
        last_nxt = item.now;
      end
      lbrt_pkg::REQ_SUCCESS: begin
        wait_nxt    = '0;
        wait_ns_nxt = '0;
        level_nxt   = level_dn;
        count_nxt   = '0;
      end
      lbrt_pkg::REQ_FAIL: begin
        if (escalate) begin
          level_nxt = level_up;
          count_nxt = '0;
        end
      end
      lbrt_pkg::REQ_NEXT: begin
        if (has_attempt) begin
          if (late) begin
            base_sec  = '0;
            base_ns   = '0;
            level_nxt = level_dn;
            count_nxt = '0;
          end else if (escalate) begin
            level_nxt = level_up;
            count_nxt = '0;
          end
          case (level_nxt)
            lbrt_pkg::LVL_CONSTANT: begin
              w_raw  = {1'b0, cfg.min_wait};
              ns_raw = {1'b0, cfg.min_ns};
            end
            lbrt_pkg::LVL_LINEAR: begin
              w_raw  = {1'b0, base_sec} + {1'b0, cfg.min_wait};
              ns_raw = {1'b0, base_ns} + {1'b0, cfg.min_ns};
            end
            lbrt_pkg::LVL_EXPONENTIAL: begin
              w_raw  = {base_sec, 1'b0};
              ns_raw = {base_ns, 1'b0};
            end
            default: begin
              w_raw  = {1'b0, base_sec};
              ns_raw = {1'b0, base_ns};
            end
          endcase
          if (w_raw > {1'b0, cfg.max_wait}) begin
            wait_nxt    = cfg.max_wait;
            wait_ns_nxt = cfg.max_ns;
          end else begin
            wait_nxt    = w_raw[lbrt_pkg::SEC_W-1:0];
            wait_ns_nxt = ns_raw[lbrt_pkg::NS_W-1:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= lbrt_pkg::LVL_IMMEDIATE;
      count_r   <= '0;
      wait_r    <= '0;
      wait_ns_r <= '0;
      last_r    <= '0;
    end else if (fire) begin
      level_r   <= level_nxt;
      count_r   <= count_nxt;
      wait_r    <= wait_nxt;
      wait_ns_r <= wait_ns_nxt;
      last_r    <= last_nxt;
    end
  end

  always_comb begin
    res_nxt.wait_seconds = wait_nxt;
    res_nxt.level        = level_nxt;
    res_nxt.retry_count  = count_nxt;
  end

endmodule
